// ===== sv/assert_macros.svh =====
// Assertion shorthands used by rdd_back. Clock is clk, reset is rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/rdd_pkg.sv =====
`default_nettype none
package rdd_pkg;

  localparam int DEPTH      = 64;
  localparam int VALUE_BITS = 8;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Port field layout
  localparam int OP_BITS    = 2;
  localparam int IN_VAL_W   = 8;
  localparam int IN_BITS    = 16;
  localparam int ELEM_BITS  = 8;
  localparam int STAT_BITS  = 2;

  // Operation codes
  localparam logic [OP_BITS-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_BITS-1:0] OP_REVERSE = 2'd1;
  localparam logic [OP_BITS-1:0] OP_DROP    = 2'd2;
  localparam logic [OP_BITS-1:0] OP_DUMP    = 2'd3;

  // Result status codes
  localparam logic [STAT_BITS-1:0] ST_ELEM     = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_ERROR    = 2'd2;
  localparam logic [STAT_BITS-1:0] ST_OVERFLOW = 2'd3;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [CNT_W:0]        sum_t;
  typedef logic [ELEM_BITS-1:0]  elem_t;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    value_t             value;
  } cmd_t;

  // Fold a sum below 2*DEPTH back into the ring.
  function automatic idx_t wrap_idx(sum_t s);
    sum_t r;
    r = (s >= sum_t'(DEPTH)) ? (s - sum_t'(DEPTH)) : s;
    return idx_t'(r);
  endfunction

endpackage
`default_nettype wire

// ===== sv/rdd_front.sv =====
`default_nettype none
module rdd_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [rdd_pkg::IN_BITS-1:0] s_tdata,
  output logic                            cmd_valid,
  input  wire logic                       cmd_ready,
  output rdd_pkg::cmd_t                   cmd
);

  logic          f_valid;
  rdd_pkg::cmd_t f_cmd;
  logic          take;
  logic          push;

  assign push     = f_valid && cmd_ready;
  assign s_tready = !f_valid || cmd_ready;
  assign take     = s_tvalid && s_tready;

  assign cmd_valid = f_valid;
  assign cmd       = f_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (take) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  // Split the transfer into opcode and value, keep value to the store width
  always_ff @(posedge clk) begin
    if (take) begin
      f_cmd.op    <= s_tdata[rdd_pkg::OP_BITS-1:0];
      f_cmd.value <= rdd_pkg::value_t'(
        s_tdata[rdd_pkg::OP_BITS +: rdd_pkg::IN_VAL_W]);
    end
  end

endmodule
`default_nettype wire

// ===== sv/rdd_fifo.sv =====
`default_nettype none
module rdd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_valid,
  output logic               wr_ready,
  input  wire rdd_pkg::cmd_t wr_cmd,
  output logic               rd_valid,
  input  wire logic          rd_ready,
  output rdd_pkg::cmd_t      rd_cmd
);

  rdd_pkg::cmd_t                  entries [rdd_pkg::QUEUE_DEPTH];
  logic [rdd_pkg::QPTR_W-1:0]     wptr;
  logic [rdd_pkg::QPTR_W-1:0]     rptr;
  logic [rdd_pkg::QCNT_W-1:0]     fill;
  logic                           wr_en;
  logic                           rd_en;

  assign wr_ready = fill != rdd_pkg::QCNT_W'(rdd_pkg::QUEUE_DEPTH);
  assign rd_valid = fill != '0;
  assign rd_cmd   = entries[rptr];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (wr_en) begin
        wptr <= (wptr == rdd_pkg::QPTR_W'(rdd_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= (rptr == rdd_pkg::QPTR_W'(rdd_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wptr] <= wr_cmd;
    end
  end

endmodule
`default_nettype wire

// ===== sv/rdd_back.sv =====
`default_nettype none
`include "assert_macros.svh"
module rdd_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cmd_valid,
  output logic                               cmd_ready,
  input  wire rdd_pkg::cmd_t                 cmd,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [rdd_pkg::ELEM_BITS-1:0]      m_tdata,
  output logic [rdd_pkg::STAT_BITS-1:0]      m_tuser,
  output logic                               m_tlast
);

  // List state
  rdd_pkg::idx_t head;
  rdd_pkg::cnt_t count;
  logic          rev;
  logic          err;
  logic          ovf;
  logic          dumping;
  rdd_pkg::cnt_t k;

  // Element store and its registered read port
  rdd_pkg::value_t mem [rdd_pkg::DEPTH];
  rdd_pkg::value_t mem_q;

  // Read stage between store and output register
  logic                            st_valid;
  logic [rdd_pkg::STAT_BITS-1:0]   st_status;
  logic                            st_last;
  logic                            st_use_mem;

  // Output register
  logic                            out_valid;
  rdd_pkg::elem_t                  out_elem;
  logic [rdd_pkg::STAT_BITS-1:0]   out_status;
  logic                            out_last;

  logic            rd_move;
  logic            issue_ok;
  logic            pop;
  logic            is_dump;
  logic            dump_status;
  logic            issue;
  logic            dump_last;
  logic [rdd_pkg::STAT_BITS-1:0] flag_status;
  rdd_pkg::cnt_t   off;
  rdd_pkg::idx_t   rd_idx;
  rdd_pkg::idx_t   wr_idx;
  rdd_pkg::idx_t   head_inc;
  logic            wr_en;

  assign rd_move  = st_valid && (!out_valid || m_tready);
  assign issue_ok = !st_valid || rd_move;
  assign is_dump  = cmd.op == rdd_pkg::OP_DUMP;
  assign cmd_ready = !dumping && (!is_dump || issue_ok);
  assign pop      = cmd_valid && cmd_ready;

  assign dump_status = err || ovf || (count == '0);
  assign flag_status = err ? rdd_pkg::ST_ERROR :
                       ovf ? rdd_pkg::ST_OVERFLOW : rdd_pkg::ST_EMPTY;
  assign issue = (pop && is_dump && dump_status) || (dumping && issue_ok);

  assign dump_last = (k + rdd_pkg::cnt_t'(1)) == count;
  assign off       = rev ? (count - rdd_pkg::cnt_t'(1) - k) : k;
  assign rd_idx    = rdd_pkg::wrap_idx(rdd_pkg::sum_t'(head) + rdd_pkg::sum_t'(off));
  assign wr_idx    = rdd_pkg::wrap_idx(rdd_pkg::sum_t'(head) + rdd_pkg::sum_t'(count));
  assign head_inc  = rdd_pkg::wrap_idx(rdd_pkg::sum_t'(head) + rdd_pkg::sum_t'(1));
  assign wr_en     = pop && !err && (cmd.op == rdd_pkg::OP_LOAD)
                     && (count != rdd_pkg::cnt_t'(rdd_pkg::DEPTH));

  assign m_tvalid = out_valid;
  assign m_tdata  = out_elem;
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= cmd.value;
    end
    if (issue) begin
      mem_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      rev       <= 1'b0;
      err       <= 1'b0;
      ovf       <= 1'b0;
      dumping   <= 1'b0;
      k         <= '0;
      st_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rd_move) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      if (issue) begin
        st_valid <= 1'b1;
      end else if (rd_move) begin
        st_valid <= 1'b0;
      end

      if (dumping) begin
        if (issue_ok) begin
          k <= k + rdd_pkg::cnt_t'(1);
          if (dump_last) begin
            dumping <= 1'b0;
            head    <= '0;
            count   <= '0;
            rev     <= 1'b0;
          end
        end
      end else if (pop) begin
        unique case (cmd.op)
          rdd_pkg::OP_LOAD: begin
            if (!err) begin
              if (count == rdd_pkg::cnt_t'(rdd_pkg::DEPTH)) begin
                ovf <= 1'b1;
              end else begin
                count <= count + rdd_pkg::cnt_t'(1);
              end
            end
          end
          rdd_pkg::OP_REVERSE: begin
            if (!err) begin
              rev <= !rev;
            end
          end
          rdd_pkg::OP_DROP: begin
            if (!err) begin
              if (count == '0) begin
                err <= 1'b1;
              end else begin
                count <= count - rdd_pkg::cnt_t'(1);
                if (!rev) begin
                  head <= head_inc;
                end
              end
            end
          end
          rdd_pkg::OP_DUMP: begin
            if (dump_status) begin
              head  <= '0;
              count <= '0;
              rev   <= 1'b0;
              err   <= 1'b0;
              ovf   <= 1'b0;
            end else begin
              dumping <= 1'b1;
              k       <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Stage and output payloads
  always_ff @(posedge clk) begin
    if (issue) begin
      st_status  <= dumping ? rdd_pkg::ST_ELEM : flag_status;
      st_last    <= dumping ? dump_last : 1'b1;
      st_use_mem <= dumping;
    end
    if (rd_move) begin
      out_elem   <= st_use_mem ? rdd_pkg::elem_t'(mem_q) : '0;
      out_status <= st_status;
      out_last   <= st_last;
    end
  end

  `ASSERT_CLK(a_count_range, count <= rdd_pkg::cnt_t'(rdd_pkg::DEPTH), "count beyond depth")
  `ASSERT_IMPL(a_dump_clean, dumping, !err && !ovf && (count != '0), "dump with flags set")
  `ASSERT_IMPL(a_status_last, out_valid && (out_status != rdd_pkg::ST_ELEM), out_last, "status result not last")
  `ASSERT_IMPL(a_no_overwrite, issue, !st_valid || rd_move, "read stage overwritten")

endmodule
`default_nettype wire

// ===== sv/reversible_deque_drop_engine_unit.sv =====
`default_nettype none
// Channel  Dir  Signals                        Payload (lowest bit up)
// s        in   s_tvalid s_tready s_tdata[15:0] operation[1:0] value[9:2] pad
// m        out  m_tvalid m_tready m_tdata[7:0]  element[7:0]
//                m_tuser[1:0] m_tlast            status[1:0]; last on tlast
//
// Load, reverse and drop retire one per cycle at the back end while no dump
// streams; a command passes the front register and the four-entry queue first.
// A status-only dump issues in the cycle it is popped and reaches m through the
// read stage and output register; an element dump enters its dumping state, then
// streams one element per unstalled cycle out of the store's single read port.
// Reset (rst, synchronous) clears pointers, count and flags; no clearing pass.
// A stall on m holds the output register and stops dumps; front register and queue
// then hold up to five commands before s_tready drops.
module reversible_deque_drop_engine_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [rdd_pkg::IN_BITS-1:0]   s_tdata,   // operation, value, zero pad
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [rdd_pkg::ELEM_BITS-1:0]      m_tdata,   // element
  output logic [rdd_pkg::STAT_BITS-1:0]      m_tuser,   // status
  output logic                               m_tlast
);

  // Front register to queue
  logic          f_valid;
  logic          f_ready;
  rdd_pkg::cmd_t f_cmd;

  // Queue to back end
  logic          q_valid;
  logic          q_ready;
  rdd_pkg::cmd_t q_cmd;

  // Accept and split each transfer
  rdd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  // Hold commands while the back end streams a dump
  rdd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  // Execute against the ring store and drive results
  rdd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire

// ===== tb/rdd_stream_checker.sv =====
`timescale 1ns / 1ps
module rdd_stream_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  input  wire logic                        s_tready,
  input  wire logic [rdd_pkg::IN_BITS-1:0] s_tdata,   // operation, value, zero pad
  input  wire logic                        m_tvalid,
  input  wire logic                        m_tready,
  input  wire logic [rdd_pkg::ELEM_BITS-1:0] m_tdata, // element
  input  wire logic [rdd_pkg::STAT_BITS-1:0] m_tuser, // status
  input  wire logic                        m_tlast,
  output int                               fail_count,
  output int                               results_due
);

  // Room for every word of the dumps that can be in flight at once
  localparam int DUE_DEPTH = 1024;

  typedef struct packed {
    rdd_pkg::elem_t                element;
    logic [rdd_pkg::STAT_BITS-1:0] status;
    logic                          last;
  } dump_word_t;

  // Shadow of the deque
  rdd_pkg::value_t ring [rdd_pkg::DEPTH];
  int         front_pos   = 0;
  int         fill        = 0;
  logic       flipped     = 1'b0;
  logic       drop_fault  = 1'b0;
  logic       spilled     = 1'b0;
  int         mism        = 0;

  // Expected words, oldest first
  dump_word_t due_words [DUE_DEPTH];
  int         due_rd      = 0;
  int         due_wr      = 0;
  int         due_count   = 0;

  function automatic dump_word_t dump_word(input rdd_pkg::elem_t e,
                                           input logic [rdd_pkg::STAT_BITS-1:0] st,
                                           input logic l);
    dump_word_t w;
    w.element = e;
    w.status  = st;
    w.last    = l;
    return w;
  endfunction

  task automatic due_add(input dump_word_t w);
    if (due_count == DUE_DEPTH) begin
      mism++;
      $display("%0t: expected-word store full: expected room, got %0d words waiting",
               $time, due_count);
    end else begin
      due_words[due_wr] = w;
      due_wr = (due_wr + 1) % DUE_DEPTH;
      due_count++;
    end
  endtask

  task automatic due_take(output dump_word_t w);
    w = due_words[due_rd];
    due_rd = (due_rd + 1) % DUE_DEPTH;
    due_count--;
  endtask

  task automatic clear_deque();
    front_pos  = 0;
    fill       = 0;
    flipped    = 1'b0;
    drop_fault = 1'b0;
    spilled    = 1'b0;
  endtask

  // Advance the shadow by one command; a dump queues every word it must produce.
  task automatic apply_command(input logic [rdd_pkg::OP_BITS-1:0] op,
                               input rdd_pkg::value_t val);
    int k;
    int off;
    if (op == rdd_pkg::OP_DUMP) begin
      if (drop_fault)
        due_add(dump_word('0, rdd_pkg::ST_ERROR, 1'b1));
      else if (spilled)
        due_add(dump_word('0, rdd_pkg::ST_OVERFLOW, 1'b1));
      else if (fill == 0)
        due_add(dump_word('0, rdd_pkg::ST_EMPTY, 1'b1));
      else begin
        for (k = 0; k < fill; k++) begin
          off = flipped ? (fill - 1 - k) : k;
          due_add(dump_word(rdd_pkg::elem_t'(ring[(front_pos + off) % rdd_pkg::DEPTH]),
                            rdd_pkg::ST_ELEM, k == fill - 1));
        end
      end
      clear_deque();
    end else if (!drop_fault) begin
      case (op)
        rdd_pkg::OP_LOAD: begin
          if (fill >= rdd_pkg::DEPTH) spilled = 1'b1;
          else begin
            ring[(front_pos + fill) % rdd_pkg::DEPTH] = val;
            fill++;
          end
        end
        rdd_pkg::OP_REVERSE: flipped = !flipped;
        rdd_pkg::OP_DROP: begin
          if (fill == 0) drop_fault = 1'b1;
          else begin
            if (!flipped) front_pos = (front_pos + 1) % rdd_pkg::DEPTH;
            fill--;
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic check_word(input dump_word_t got);
    dump_word_t want;
    if (due_count == 0) begin
      mism++;
      $display("%0t: unexpected result: expected none, got element %0d status %0d last %0b",
               $time, got.element, got.status, got.last);
    end else begin
      due_take(want);
      if (got.element !== want.element) begin
        mism++;
        $display("%0t: element mismatch: expected %0d, got %0d",
                 $time, want.element, got.element);
      end
      if (got.status !== want.status) begin
        mism++;
        $display("%0t: status mismatch: expected %0d, got %0d",
                 $time, want.status, got.status);
      end
      if (got.last !== want.last) begin
        mism++;
        $display("%0t: last mismatch: expected %0b, got %0b", $time, want.last, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_deque();
      due_rd    = 0;
      due_wr    = 0;
      due_count = 0;
      mism = 0;
      fail_count  <= 0;
      results_due <= 0;
    end else begin
      if (s_tvalid && s_tready)
        apply_command(s_tdata[rdd_pkg::OP_BITS-1:0],
                      s_tdata[rdd_pkg::OP_BITS +: rdd_pkg::IN_VAL_W]);
      if (m_tvalid && m_tready)
        check_word(dump_word(m_tdata, m_tuser, m_tlast));
      fail_count  <= mism;
      results_due <= due_count;
    end
  end

endmodule

// ===== tb/tb_reversible_deque_drop_engine_unit.sv =====
`timescale 1ns / 1ps
module tb_reversible_deque_drop_engine_unit;

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [rdd_pkg::IN_BITS-1:0]   s_tdata;    // operation[1:0], value[9:2], zero pad
  logic                          m_tvalid;
  logic                          m_tready;
  logic [rdd_pkg::ELEM_BITS-1:0] m_tdata;    // element[7:0]
  logic [rdd_pkg::STAT_BITS-1:0] m_tuser;    // status[1:0]
  logic                          m_tlast;

  int fail_count;
  int results_due;

  // Percentages of cycles in which each side idles; the phases change them.
  int send_gap_pct  = 24;
  int drain_gap_pct = 47;
  // Remaining cycles of a forced receiver hold-off.
  int hold_len      = 0;
  int items_sent    = 0;

  reversible_deque_drop_engine_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  rdd_stream_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #4_800_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver: accept at random, or hold off completely while a hold-off is pending.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        hold_len--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= drain_gap_pct);
      end
    end
  end

  function automatic logic [rdd_pkg::IN_VAL_W-1:0] rand_byte();
    return rdd_pkg::IN_VAL_W'($urandom_range(255));
  endfunction

  // Offer one command and hold it until the transfer completes. Idle cycles go in
  // front of it; valid stays high across back-to-back items.
  task automatic send_cmd(input logic [rdd_pkg::OP_BITS-1:0] op,
                          input logic [rdd_pkg::IN_VAL_W-1:0] val);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(rdd_pkg::IN_BITS - rdd_pkg::OP_BITS - rdd_pkg::IN_VAL_W){1'b0}}, val, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Drive the store up to exactly full with the head moved well off zero, so the
  // ring wraps; optionally push past full to raise overflow. Then dump it all.
  task automatic fill_session(input logic spill);
    int held;
    held = 0;
    repeat ($urandom_range(30, 50)) begin
      send_cmd(rdd_pkg::OP_LOAD, rand_byte());
      held++;
    end
    // Drops from both ends; reversal decides which end goes.
    repeat ($urandom_range(10, 25)) begin
      if ($urandom_range(3) == 0) send_cmd(rdd_pkg::OP_REVERSE, rand_byte());
      send_cmd(rdd_pkg::OP_DROP, rand_byte());
      held--;
    end
    while (held < rdd_pkg::DEPTH) begin
      send_cmd(rdd_pkg::OP_LOAD, rand_byte());
      held++;
    end
    if (spill) begin
      repeat ($urandom_range(1, 3)) send_cmd(rdd_pkg::OP_LOAD, rand_byte());
    end
    send_cmd(rdd_pkg::OP_DUMP, rand_byte());
  endtask

  // One random session: mostly a short well-formed list closed by a dump,
  // sometimes raw noise, now and then a full-store run.
  task automatic mixed_session();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      fill_session(1'($urandom_range(1)));
    end else if (pick < 25) begin
      repeat ($urandom_range(1, 12))
        send_cmd(rdd_pkg::OP_BITS'($urandom_range(3)), rand_byte());
    end else begin
      repeat ($urandom_range(1, 20)) begin
        pick = $urandom_range(99);
        if (pick < 55)      send_cmd(rdd_pkg::OP_LOAD, rand_byte());
        else if (pick < 70) send_cmd(rdd_pkg::OP_REVERSE, rand_byte());
        else                send_cmd(rdd_pkg::OP_DROP, rand_byte());
      end
      send_cmd(rdd_pkg::OP_DUMP, rand_byte());
    end
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Dump of an empty list
    send_cmd(rdd_pkg::OP_DUMP, 8'h00);
    // Value extremes, dumped in order
    send_cmd(rdd_pkg::OP_LOAD, 8'h00);
    send_cmd(rdd_pkg::OP_LOAD, 8'hFF);
    send_cmd(rdd_pkg::OP_LOAD, 8'h5A);
    send_cmd(rdd_pkg::OP_DUMP, 8'hA5);
    // Reversed dump
    send_cmd(rdd_pkg::OP_LOAD, 8'h01);
    send_cmd(rdd_pkg::OP_LOAD, 8'h02);
    send_cmd(rdd_pkg::OP_LOAD, 8'h03);
    send_cmd(rdd_pkg::OP_REVERSE, 8'hFF);
    send_cmd(rdd_pkg::OP_DUMP, 8'h00);
    // Drop from the tail while reversed, then from the head
    send_cmd(rdd_pkg::OP_LOAD, 8'd10);
    send_cmd(rdd_pkg::OP_LOAD, 8'd20);
    send_cmd(rdd_pkg::OP_LOAD, 8'd30);
    send_cmd(rdd_pkg::OP_REVERSE, 8'h00);
    send_cmd(rdd_pkg::OP_DROP, 8'hFF);
    send_cmd(rdd_pkg::OP_REVERSE, 8'h00);
    send_cmd(rdd_pkg::OP_DROP, 8'h00);
    send_cmd(rdd_pkg::OP_DUMP, 8'h00);
    // Drop on empty: sticky error, later commands ignored until the dump
    send_cmd(rdd_pkg::OP_DROP, 8'h00);
    send_cmd(rdd_pkg::OP_LOAD, 8'h07);
    send_cmd(rdd_pkg::OP_REVERSE, 8'h00);
    send_cmd(rdd_pkg::OP_DROP, 8'h00);
    send_cmd(rdd_pkg::OP_DUMP, 8'h00);

    // Stall the output behind a pending dump and keep offering commands, so the
    // command queue fills and s_tready drops for a long stretch.
    repeat (6) send_cmd(rdd_pkg::OP_LOAD, rand_byte());
    send_cmd(rdd_pkg::OP_DUMP, rand_byte());
    hold_len = 300;
    repeat (4) mixed_session();

    // Phase one: sender idles lightly, receiver heavily.
    fill_session(1'b0);
    while (items_sent < 170) mixed_session();

    // Phase two: the other way round.
    send_gap_pct  = 47;
    drain_gap_pct = 24;
    while (items_sent < 315) mixed_session();

    // Phase three: no idling on either side.
    send_gap_pct  = 0;
    drain_gap_pct = 0;
    fill_session(1'b1);
    while (items_sent < 420) mixed_session();

    s_tvalid <= 1'b0;
    // Let the checker see the last transfer before trusting its count.
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/rdd_pkg.sv
sv/rdd_front.sv
sv/rdd_fifo.sv
sv/rdd_back.sv
sv/reversible_deque_drop_engine_unit.sv
tb/rdd_stream_checker.sv
tb/tb_reversible_deque_drop_engine_unit.sv
